// ----- rtl/s5scan_pkg.sv -----
`default_nettype none
package s5scan_pkg;

    localparam logic [31:0] SIG_WORD     = 32'h5F53355F;
    localparam logic [7:0]  PKG_OP       = 8'h12;
    localparam logic [7:0]  BYTE_PREFIX  = 8'h0A;
    localparam logic [32:0] WINDOW_SLACK = 33'd8;
    localparam logic [31:0] SIG_TAIL     = 32'd3;
    localparam logic [7:0]  DEFAULT_TYPE = 8'd7;

    localparam logic CFG_STREAM_LENGTH = 1'b0;
    localparam logic CFG_DEFAULT_TYPE  = 1'b1;

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_PKGOP,
        PH_LEAD,
        PH_LENSKIP,
        PH_NUMEL,
        PH_ELEM_A,
        PH_VAL_A,
        PH_ELEM_B,
        PH_VAL_B,
        PH_DONE
    } phase_t;

endpackage
`default_nettype wire

// ----- rtl/aml_s5_sleep_type_scan.sv -----
// A byte taken from s_axis is held in the input stage register and parsed from
// there; the result for the byte marked tlast is registered for m_axis.
// Throughput: one byte per cycle, limited by the single parse stage; a tlast
// byte waits in the input stage while the previous result is still unread.
// Reset (rst_n low, async): parse state cleared, stream_length = 0,
// default sleep type = 7, no request pending on either side.
`default_nettype none
module aml_s5_sleep_type_scan (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] aml_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] found, [8:1] sleep_type_a, [9] type_a_valid,
    // [17:10] sleep_type_b, [18] type_b_valid, [23:19] zero
    output      logic [23:0] m_axis_tdata,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import s5scan_pkg::*;

    logic [31:0] stream_length_reg;
    logic [7:0]  default_type_reg;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // stream state
    logic [23:0] recent_reg,  recent_next;
    logic [31:0] pos_reg,     pos_next;
    phase_t      phase_reg,   phase_next;
    logic [1:0]  skip_reg,    skip_next;
    logic        match_reg,   match_next;
    logic        a_valid_reg, a_valid_next;
    logic [7:0]  a_val_reg,   a_val_next;
    logic        b_valid_reg, b_valid_next;
    logic [7:0]  b_val_reg,   b_val_next;

    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [23:0] out_data_next;

    logic out_free;
    logic advance;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    // only a last byte needs room in the result register
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        logic [31:0] window;
        logic [32:0] win_end;
        logic [1:0]  extra;
        logic [1:0]  skip_dec;

        window  = {recent_reg, in_byte_reg};
        win_end = {1'b0, pos_reg - SIG_TAIL} + WINDOW_SLACK;
        extra   = in_byte_reg[7:6];
        skip_dec = skip_reg - 2'd1;

        phase_next   = phase_reg;
        skip_next    = skip_reg;
        match_next   = match_reg;
        a_valid_next = a_valid_reg;
        a_val_next   = a_val_reg;
        b_valid_next = b_valid_reg;
        b_val_next   = b_val_reg;

        if (pos_reg < stream_length_reg)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (window == SIG_WORD && pos_reg >= SIG_TAIL
                        && win_end < {1'b0, stream_length_reg})
                    begin
                        match_next = 1'b1;
                        phase_next = PH_PKGOP;
                    end
                end
                PH_PKGOP, PH_LEAD:
                begin
                    if (phase_reg == PH_PKGOP && in_byte_reg == PKG_OP)
                        phase_next = PH_LEAD;
                    else if (extra == 2'd0)
                        phase_next = PH_NUMEL;
                    else
                    begin
                        skip_next  = extra;
                        phase_next = PH_LENSKIP;
                    end
                end
                PH_LENSKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 2'd0)
                        phase_next = PH_NUMEL;
                end
                PH_NUMEL:
                    phase_next = PH_ELEM_A;
                PH_ELEM_A, PH_VAL_A:
                begin
                    if (phase_reg == PH_ELEM_A && in_byte_reg == BYTE_PREFIX)
                        phase_next = PH_VAL_A;
                    else
                    begin
                        a_valid_next = 1'b1;
                        a_val_next   = in_byte_reg;
                        phase_next   = PH_ELEM_B;
                    end
                end
                PH_ELEM_B, PH_VAL_B:
                begin
                    if (phase_reg == PH_ELEM_B && in_byte_reg == BYTE_PREFIX)
                        phase_next = PH_VAL_B;
                    else
                    begin
                        b_valid_next = 1'b1;
                        b_val_next   = in_byte_reg;
                        phase_next   = PH_DONE;
                    end
                end
                default:
                    phase_next = phase_reg;
            endcase
        end

        recent_next = {recent_reg[15:0], in_byte_reg};
        pos_next    = (pos_reg == '1) ? pos_reg : pos_reg + 32'd1;

        out_data_next = {5'd0,
                         b_valid_next, b_valid_next ? b_val_next : default_type_reg,
                         a_valid_next, a_valid_next ? a_val_next : default_type_reg,
                         match_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= '0;
            default_type_reg  <= DEFAULT_TYPE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STREAM_LENGTH: stream_length_reg <= cfg_data;
                CFG_DEFAULT_TYPE:  default_type_reg  <= cfg_data[7:0];
                default:           stream_length_reg <= stream_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg  <= '0;
            pos_reg     <= '0;
            phase_reg   <= PH_SEARCH;
            skip_reg    <= '0;
            match_reg   <= 1'b0;
            a_valid_reg <= 1'b0;
            a_val_reg   <= '0;
            b_valid_reg <= 1'b0;
            b_val_reg   <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                // report done, next byte opens a new stream
                recent_reg  <= '0;
                pos_reg     <= '0;
                phase_reg   <= PH_SEARCH;
                skip_reg    <= '0;
                match_reg   <= 1'b0;
                a_valid_reg <= 1'b0;
                a_val_reg   <= '0;
                b_valid_reg <= 1'b0;
                b_val_reg   <= '0;
            end
            else
            begin
                recent_reg  <= recent_next;
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                skip_reg    <= skip_next;
                match_reg   <= match_next;
                a_valid_reg <= a_valid_next;
                a_val_reg   <= a_val_next;
                b_valid_reg <= b_valid_next;
                b_val_reg   <= b_val_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

// ----- tb/aml_s5_sleep_type_scan_tb.sv -----
`timescale 1ns / 1ps
module aml_s5_sleep_type_scan_tb;
    import s5scan_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } aml_item_t;

    // same bit order as m_axis_tdata[18:0], found in bit 0
    typedef struct packed {
        logic       b_valid;
        logic [7:0] type_b;
        logic       a_valid;
        logic [7:0] type_a;
        logic       found;
    } s5_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_STREAM_LENGTH;
    logic [31:0] cfg_data = 32'h0;

    aml_item_t   byte_q[$];
    s5_report_t  report_q[$];
    int          bytes_taken = 0;
    int          mismatch_cnt = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    logic        tx_valid_nxt;
    logic        rx_ready_nxt;
    logic        quiet = 1'b0;
    logic        rx_hold = 1'b0;

    // scanner copy: registers and per-stream state
    logic [31:0] len_reg = 32'd0;
    logic [7:0]  dflt_reg = DEFAULT_TYPE;
    logic [23:0] hist = 24'h0;
    logic [31:0] pos = 32'h0;
    phase_t      phase = PH_SEARCH;
    logic [1:0]  skip_left = 2'd0;
    logic        match = 1'b0;
    logic [8:0]  held_a = 9'h0;
    logic [8:0]  held_b = 9'h0;

    aml_s5_sleep_type_scan i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic take_lead(input logic [7:0] b);
        if (b[7:6] == 2'd0)
        begin
            phase = PH_NUMEL;
        end
        else
        begin
            skip_left = b[7:6];
            phase = PH_LENSKIP;
        end
    endtask

    task automatic scan_aml_byte(input logic [7:0] b, input logic last);
        logic [31:0] win;
        s5_report_t  rep;
        win = {hist, b};
        if (pos < len_reg)
        begin
            case (phase)
                PH_SEARCH:
                    if (win == SIG_WORD && pos >= SIG_TAIL &&
                        ({1'b0, pos} - {1'b0, SIG_TAIL} + WINDOW_SLACK) < {1'b0, len_reg})
                    begin
                        match = 1'b1;
                        phase = PH_PKGOP;
                    end
                PH_PKGOP:
                    if (b == PKG_OP)
                        phase = PH_LEAD;
                    else
                        take_lead(b);
                PH_LEAD:
                    take_lead(b);
                PH_LENSKIP:
                begin
                    skip_left = skip_left - 2'd1;
                    if (skip_left == 2'd0)
                        phase = PH_NUMEL;
                end
                PH_NUMEL:
                    phase = PH_ELEM_A;
                PH_ELEM_A:
                    if (b == BYTE_PREFIX)
                        phase = PH_VAL_A;
                    else
                    begin
                        held_a = {1'b1, b};
                        phase = PH_ELEM_B;
                    end
                PH_VAL_A:
                begin
                    held_a = {1'b1, b};
                    phase = PH_ELEM_B;
                end
                PH_ELEM_B:
                    if (b == BYTE_PREFIX)
                        phase = PH_VAL_B;
                    else
                    begin
                        held_b = {1'b1, b};
                        phase = PH_DONE;
                    end
                PH_VAL_B:
                begin
                    held_b = {1'b1, b};
                    phase = PH_DONE;
                end
                default: ;
            endcase
        end
        hist = {hist[15:0], b};
        if (pos != 32'hFFFF_FFFF)
            pos = pos + 32'd1;
        if (last)
        begin
            rep.found   = match;
            rep.type_a  = held_a[8] ? held_a[7:0] : dflt_reg;
            rep.a_valid = held_a[8];
            rep.type_b  = held_b[8] ? held_b[7:0] : dflt_reg;
            rep.b_valid = held_b[8];
            report_q.push_back(rep);
            hist      = 24'h0;
            pos       = 32'h0;
            phase     = PH_SEARCH;
            skip_left = 2'd0;
            match     = 1'b0;
            held_a    = 9'h0;
            held_b    = 9'h0;
        end
    endtask

    // sender: valid stays up until the request is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_aml_byte(s_axis_tdata, s_axis_tlast);
                void'(byte_q.pop_front());
                bytes_taken++;
            end
            tx_valid_nxt = 1'b0;
            if (s_axis_tvalid && !s_axis_tready)
                tx_valid_nxt = 1'b1;
            else if (tx_gap > 0)
                tx_gap--;
            else if (byte_q.size() > 0)
            begin
                if (!quiet && $urandom_range(0, 7) == 0)
                    tx_gap = $urandom_range(1, 16) - 1;
                else
                    tx_valid_nxt = 1'b1;
            end
            s_axis_tvalid <= tx_valid_nxt;
            if (tx_valid_nxt)
            begin
                s_axis_tdata <= byte_q[0].data;
                s_axis_tlast <= byte_q[0].last;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (report_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    s5_report_t exp_rep;
                    s5_report_t got;
                    exp_rep = report_q.pop_front();
                    got = m_axis_tdata[18:0];
                    if (m_axis_tdata !== {5'b0, exp_rep})
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch found %b/%b a %h/%h av %b/%b b %h/%h bv %b/%b pad %h",
                                     exp_rep.found, got.found, exp_rep.type_a, got.type_a,
                                     exp_rep.a_valid, got.a_valid, exp_rep.type_b, got.type_b,
                                     exp_rep.b_valid, got.b_valid, m_axis_tdata[23:19]);
                    end
                end
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                rx_ready_nxt = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                rx_gap = $urandom_range(1, 16) - 1;
                rx_ready_nxt = 1'b0;
            end
            else
                rx_ready_nxt = 1'b1;
            if (rx_hold)
                rx_ready_nxt = 1'b0;
            m_axis_tready <= rx_ready_nxt;
        end
    end

    // long receiver stall so the result path backs up into the input
    initial
    begin
        while (bytes_taken < 250)
            @(negedge clk);
        rx_hold = 1'b1;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic cfg_write(input logic idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_STREAM_LENGTH)
            len_reg = value;
        else
            dflt_reg = value[7:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic drain(input int settle);
        while (byte_q.size() != 0 || report_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic push_bytes(input logic [7:0] body[$]);
        aml_item_t it;
        foreach (body[k])
        begin
            it.data = body[k];
            it.last = (k == body.size() - 1);
            byte_q.push_back(it);
        end
    endtask

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return BYTE_PREFIX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic make_stream(input logic [31:0] win_len, output int n);
        logic [7:0] body[$];
        int         s_max;
        int         cut;
        int         at;
        logic [1:0] top;
        body = {};
        if ($urandom_range(0, 4) == 0)
        begin
            // noise, sometimes with a bare signature somewhere inside
            repeat ($urandom_range(1, 30)) body.push_back(8'($urandom_range(0, 255)));
            if (body.size() >= 4 && $urandom_range(0, 2) == 0)
            begin
                at = $urandom_range(0, body.size() - 4);
                for (int k = 0; k < 4; k++)
                    body[at + k] = SIG_WORD[31 - 8 * k -: 8];
            end
        end
        else
        begin
            // place the name start near the edge of the match window
            s_max = (win_len > 48 || win_len < 9) ? 24 : win_len - 6;
            repeat ($urandom_range(0, s_max)) body.push_back(8'($urandom_range(0, 255)));
            for (int k = 0; k < 4; k++)
                body.push_back(SIG_WORD[31 - 8 * k -: 8]);
            if ($urandom_range(0, 1))
                body.push_back(PKG_OP);
            top = 2'($urandom_range(0, 3));
            body.push_back({top, 6'($urandom_range(0, 63))});
            repeat (top) body.push_back(8'($urandom_range(0, 255)));
            body.push_back(8'($urandom_range(0, 255)));
            repeat (2)
            begin
                if ($urandom_range(0, 1))
                    body.push_back(BYTE_PREFIX);
                body.push_back(pick_value());
            end
            if ($urandom_range(0, 4) == 0)
            begin
                for (int k = 0; k < 4; k++)
                    body.push_back(SIG_WORD[31 - 8 * k -: 8]);
                repeat (4) body.push_back(pick_value());
            end
            repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, body.size());
                body = body[0:cut - 1];
            end
        end
        push_bytes(body);
        n = body.size();
    endtask

    task automatic run_phase(input logic [31:0] win_len, input logic [7:0] dflt, inout int total);
        int want;
        int got_n;
        int phase_n;
        drain(6);
        cfg_write(CFG_STREAM_LENGTH, win_len);
        cfg_write(CFG_DEFAULT_TYPE, {24'h0, dflt});
        @(negedge clk);
        want = $urandom_range(80, 120);
        phase_n = 0;
        while (phase_n < want)
        begin
            make_stream(win_len, got_n);
            phase_n += got_n;
        end
        total += phase_n;
    endtask

    initial
    begin
        int total;
        total = 0;
        repeat (2) @(posedge clk);
        rst_n = 1'b1;

        cfg_write(CFG_STREAM_LENGTH, 32'd12);
        @(negedge clk);
        // match at the start, package op, prefixed first value, 0xFF and 0x00 values
        push_bytes('{8'h5F, 8'h53, 8'h35, 8'h5F, PKG_OP, 8'h00, 8'h03, BYTE_PREFIX,
                     8'hFF, 8'h00});
        // name starts one byte too late for the window, then the package op
        push_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h5F, 8'h53, 8'h35, 8'h5F, PKG_OP});
        // last in-window match, long length field, prefix as the final byte
        push_bytes('{8'h00, 8'h00, 8'h00, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h80, 8'h01,
                     8'h02, 8'h03, BYTE_PREFIX});
        total = 31;

        run_phase(32'd8, 8'h00, total);
        run_phase(32'd0, 8'hFF, total);
        run_phase(32'hFFFF_FFFF, 8'($urandom_range(0, 255)), total);
        while (total < 650)
            run_phase(32'($urandom_range(9, 40)), 8'($urandom_range(0, 255)), total);

        // tail of the run with no idling on either side
        drain(6);
        quiet = 1'b1;
        run_phase(32'($urandom_range(9, 40)), DEFAULT_TYPE, total);

        drain(10);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/s5scan_pkg.sv
rtl/aml_s5_sleep_type_scan.sv
tb/aml_s5_sleep_type_scan_tb.sv
